// ===== rtl/rlks_pkg.sv =====
package rlks_pkg;

	localparam int ROWS     = 4;
	localparam int SAMPLE_W = 15;
	localparam int LEVEL_W  = 5;
	localparam int NUM_W    = 22;
	localparam int CFG_IDX_W = 3;

	localparam logic [LEVEL_W-1:0] NO_KEY = 5'd31;

	// register order: row 3 .. row 0
	localparam logic [ROWS-1:0][LEVEL_W-1:0] SCALE_RESET = {5'd16, 5'd15, 5'd2, 5'd16};

	localparam logic [1:0] MOD_NONE  = 2'd0;
	localparam logic [1:0] MOD_SHIFT = 2'd1;
	localparam logic [1:0] MOD_EXTRA = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_CHECK,
		ST_EMIT
	} back_state_t;

	// one scan attempt after clamping, with the maximum of each set
	typedef struct packed {
		logic [ROWS-1:0][SAMPLE_W-1:0] set_a;
		logic [ROWS-1:0][SAMPLE_W-1:0] set_b;
		logic [SAMPLE_W-1:0]           max_a;
		logic [SAMPLE_W-1:0]           max_b;
	} scan_t;

endpackage

// ===== rtl/resistor_ladder_key_scanner_core.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   first_sample_a..d, second_sample_a..d (s16)
// out       output     out_valid / out_ready row_index, key_index, is_press, modifier, last_event
// cfg       input      cfg_we (no wait)      cfg_index, cfg_data
//
// In the back end a scan is pulled from the queue, then each row gets a setup
// state and five restoring divide steps (both sets divided side by side), then a
// compare state, after which the scan's events are emitted one at a time.
// The two-entry queue lets the input side take further scans while one is worked.
// Reset clears stored levels to no key and scale registers to 16, 2, 15, 16.
// A full output register holds the back end in its emit state until taken.
module resistor_ladder_key_scanner_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                first_sample_a,
	input  logic signed [15:0]                first_sample_b,
	input  logic signed [15:0]                first_sample_c,
	input  logic signed [15:0]                first_sample_d,
	input  logic signed [15:0]                second_sample_a,
	input  logic signed [15:0]                second_sample_b,
	input  logic signed [15:0]                second_sample_c,
	input  logic signed [15:0]                second_sample_d,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        row_index,
	output logic [4:0]                        key_index,
	output logic                              is_press,
	output logic [1:0]                        modifier,
	output logic                              last_event,

	input  logic                              cfg_we,
	input  logic [rlks_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rlks_pkg::LEVEL_W-1:0]      cfg_data
);

	// per-row quantization steps; index four and up is dropped
	logic [rlks_pkg::ROWS-1:0][rlks_pkg::LEVEL_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= rlks_pkg::SCALE_RESET;
		end else if (cfg_we && cfg_index[rlks_pkg::CFG_IDX_W-1] == 1'b0) begin
			scale_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	logic            q_push, q_full, q_pop, q_valid;
	rlks_pkg::scan_t q_wdata, q_rdata;

	// front: clamp negatives, find each set's maximum
	rlks_front u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.first_sample_a  (first_sample_a),
		.first_sample_b  (first_sample_b),
		.first_sample_c  (first_sample_c),
		.first_sample_d  (first_sample_d),
		.second_sample_a (second_sample_a),
		.second_sample_b (second_sample_b),
		.second_sample_c (second_sample_c),
		.second_sample_d (second_sample_d),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_data          (q_wdata)
	);

	rlks_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_rdata)
	);

	// back: quantize, compare the two sets, emit release/press transactions
	rlks_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale      (scale_q),
		.q_valid    (q_valid),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row_index  (row_index),
		.key_index  (key_index),
		.is_press   (is_press),
		.modifier   (modifier),
		.last_event (last_event)
	);

endmodule

// ===== rtl/rlks_front.sv =====
module rlks_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] first_sample_a,
	input  logic signed [15:0] first_sample_b,
	input  logic signed [15:0] first_sample_c,
	input  logic signed [15:0] first_sample_d,
	input  logic signed [15:0] second_sample_a,
	input  logic signed [15:0] second_sample_b,
	input  logic signed [15:0] second_sample_c,
	input  logic signed [15:0] second_sample_d,
	input  logic               q_full,
	output logic               q_push,
	output rlks_pkg::scan_t    q_data
);

	function automatic logic [rlks_pkg::SAMPLE_W-1:0] clamp(input logic signed [15:0] v);
		clamp = v[15] ? '0 : v[rlks_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic logic [rlks_pkg::SAMPLE_W-1:0] max2(
		input logic [rlks_pkg::SAMPLE_W-1:0] x,
		input logic [rlks_pkg::SAMPLE_W-1:0] y
	);
		max2 = (x > y) ? x : y;
	endfunction

	logic [rlks_pkg::ROWS-1:0][rlks_pkg::SAMPLE_W-1:0] set_a;
	logic [rlks_pkg::ROWS-1:0][rlks_pkg::SAMPLE_W-1:0] set_b;

	always_comb begin
		set_a[0] = clamp(first_sample_a);
		set_a[1] = clamp(first_sample_b);
		set_a[2] = clamp(first_sample_c);
		set_a[3] = clamp(first_sample_d);
		set_b[0] = clamp(second_sample_a);
		set_b[1] = clamp(second_sample_b);
		set_b[2] = clamp(second_sample_c);
		set_b[3] = clamp(second_sample_d);
		q_data.set_a = set_a;
		q_data.set_b = set_b;
		q_data.max_a = max2(max2(set_a[0], set_a[1]), max2(set_a[2], set_a[3]));
		q_data.max_b = max2(max2(set_b[0], set_b[1]), max2(set_b[2], set_b[3]));
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/rlks_fifo.sv =====
module rlks_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rlks_pkg::scan_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output rlks_pkg::scan_t pop_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rlks_pkg::scan_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	logic do_push;
	logic do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign valid    = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rlks_back.sv =====
module rlks_back (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic [rlks_pkg::ROWS-1:0][rlks_pkg::LEVEL_W-1:0] scale,
	input  logic                                             q_valid,
	input  rlks_pkg::scan_t                                  q_data,
	output logic                                             q_pop,
	output logic                                             out_valid,
	input  logic                                             out_ready,
	output logic [1:0]                                       row_index,
	output logic [4:0]                                       key_index,
	output logic                                             is_press,
	output logic [1:0]                                       modifier,
	output logic                                             last_event
);

	localparam int LW = rlks_pkg::LEVEL_W;
	localparam int NW = rlks_pkg::NUM_W;
	localparam int SW = rlks_pkg::SAMPLE_W;
	localparam int EV = 2 * rlks_pkg::ROWS;

	rlks_pkg::back_state_t state_q, state_d;

	rlks_pkg::scan_t scan_q;
	logic [1:0]      row_q;
	logic [2:0]      step_q;
	logic [1:0][NW-1:0] rem_q;
	logic [1:0][NW-1:0] dsh_q;
	logic [1:0][LW-1:0] quo_q;
	logic [rlks_pkg::ROWS-1:0][LW-1:0] lv_a_q, lv_b_q, prev_q, old_q;
	logic [EV-1:0]   pending_q;
	logic [1:0]      mod_q;

	logic            out_valid_q;
	logic [1:0]      row_out_q;
	logic [4:0]      key_out_q;
	logic            press_out_q;
	logic [1:0]      mod_out_q;
	logic            last_out_q;

	// per-lane datapath: lane 0 is the first set, lane 1 the second
	logic [1:0][SW-1:0] smp, mx;
	logic [LW-1:0]      scl;
	logic [1:0][NW-1:0] num, rem_nx;
	logic [1:0]         ge;
	logic [1:0][LW-1:0] qf, lvl;

	always_comb begin
		scl    = scale[row_q];
		smp[0] = scan_q.set_a[row_q];
		smp[1] = scan_q.set_b[row_q];
		mx[0]  = scan_q.max_a;
		mx[1]  = scan_q.max_b;
		for (int j = 0; j < 2; j++) begin
			// 2*s*scale + max, rounding half up against 2*max
			num[j] = {1'b0, ({5'b0, smp[j]} * {15'b0, scl}), 1'b0} + {7'b0, mx[j]};
			ge[j]     = (rem_q[j] >= dsh_q[j]);
			rem_nx[j] = ge[j] ? rem_q[j] - dsh_q[j] : rem_q[j];
			qf[j]     = {quo_q[j][LW-2:0], ge[j]};
			lvl[j]    = (mx[j] == '0 || qf[j] == scl) ? rlks_pkg::NO_KEY : qf[j];
		end
	end

	// event slots: 2*row is the release, 2*row+1 the press
	logic          mismatch;
	logic [EV-1:0] ev;
	logic [1:0]    mod_new;

	always_comb begin
		mismatch = (lv_a_q != lv_b_q);
		for (int i = 0; i < rlks_pkg::ROWS; i++) begin
			ev[2*i]   = (lv_a_q[i] != prev_q[i]) && (prev_q[i] != rlks_pkg::NO_KEY);
			ev[2*i+1] = (lv_a_q[i] != prev_q[i]) && (lv_a_q[i] != rlks_pkg::NO_KEY);
		end
		if (lv_a_q[1] == 5'd0) begin
			mod_new = rlks_pkg::MOD_EXTRA;
		end else if (lv_a_q[1] == 5'd1) begin
			mod_new = rlks_pkg::MOD_SHIFT;
		end else begin
			mod_new = rlks_pkg::MOD_NONE;
		end
	end

	logic [2:0]    slot;
	logic [EV-1:0] slot_oh;
	logic [EV-1:0] pending_nx;
	logic          out_load;
	logic          emit;

	always_comb begin
		slot    = '0;
		slot_oh = '0;
		for (int k = EV - 1; k >= 0; k--) begin
			if (pending_q[k]) begin
				slot    = 3'(k);
				slot_oh = EV'(1) << k;
			end
		end
		pending_nx = pending_q & ~slot_oh;
	end

	assign out_load = !out_valid_q || out_ready;
	assign emit     = (state_q == rlks_pkg::ST_EMIT) && out_load;
	assign q_pop    = (state_q == rlks_pkg::ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlks_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rlks_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = rlks_pkg::ST_LOAD;
				end
			end
			rlks_pkg::ST_LOAD: begin
				state_d = rlks_pkg::ST_DIV;
			end
			rlks_pkg::ST_DIV: begin
				if (step_q == 3'd4) begin
					state_d = (row_q == 2'd3) ? rlks_pkg::ST_CHECK : rlks_pkg::ST_LOAD;
				end
			end
			rlks_pkg::ST_CHECK: begin
				state_d = (!mismatch && ev != '0) ? rlks_pkg::ST_EMIT : rlks_pkg::ST_IDLE;
			end
			rlks_pkg::ST_EMIT: begin
				if (out_load && pending_nx == '0) begin
					state_d = rlks_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rlks_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath without reset
	always_ff @(posedge clk) begin
		case (state_q)
			rlks_pkg::ST_IDLE: begin
				scan_q <= q_data;
				row_q  <= '0;
			end
			rlks_pkg::ST_LOAD: begin
				step_q <= '0;
				for (int j = 0; j < 2; j++) begin
					rem_q[j] <= num[j];
					dsh_q[j] <= {2'b0, mx[j], 5'b0};
					quo_q[j] <= '0;
				end
			end
			rlks_pkg::ST_DIV: begin
				step_q <= step_q + 3'd1;
				for (int j = 0; j < 2; j++) begin
					rem_q[j] <= rem_nx[j];
					dsh_q[j] <= dsh_q[j] >> 1;
					quo_q[j] <= qf[j];
				end
				if (step_q == 3'd4) begin
					lv_a_q[row_q] <= lvl[0];
					lv_b_q[row_q] <= lvl[1];
					row_q         <= row_q + 2'd1;
				end
			end
			rlks_pkg::ST_CHECK: begin
				old_q <= prev_q;
				mod_q <= mod_new;
			end
			default: begin
			end
		endcase
		if (emit) begin
			row_out_q   <= slot[2:1];
			press_out_q <= slot[0];
			key_out_q   <= slot[0] ? lv_a_q[slot[2:1]] : old_q[slot[2:1]];
			mod_out_q   <= mod_q;
			last_out_q  <= (pending_nx == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= {rlks_pkg::ROWS{rlks_pkg::NO_KEY}};
			pending_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == rlks_pkg::ST_CHECK && !mismatch) begin
				prev_q    <= lv_a_q;
				pending_q <= ev;
			end else if (emit) begin
				pending_q <= pending_nx;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign row_index  = row_out_q;
	assign key_index  = key_out_q;
	assign is_press   = press_out_q;
	assign modifier   = mod_out_q;
	assign last_event = last_out_q;

`ifndef SYNTHESIS
	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rlks_pkg::ST_EMIT |-> pending_q != '0)
		else $error("emit state with no pending event");

	a_discard_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rlks_pkg::ST_CHECK && mismatch) |=> $stable(prev_q))
		else $error("discarded scan changed stored levels");

	a_div_rem_bound_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rlks_pkg::ST_DIV && scan_q.max_a != '0)
		|-> {1'b0, rem_q[0]} < {dsh_q[0], 1'b0})
		else $error("divider remainder out of range, first set");

	a_div_rem_bound_b: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rlks_pkg::ST_DIV && scan_q.max_b != '0)
		|-> {1'b0, rem_q[1]} < {dsh_q[1], 1'b0})
		else $error("divider remainder out of range, second set");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int ROWS      = rlks_pkg::ROWS;
	localparam int CFG_IDX_W = rlks_pkg::CFG_IDX_W;
	localparam int LEVEL_W   = rlks_pkg::LEVEL_W;

	// Register map of the config port
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_ROW_ZERO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_ROW_ONE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_ROW_TWO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_ROW_THREE = 3'd3;
	// indexes past the last row decode to nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST      = 3'd7;

	localparam int IDLE_PCT      = 34;   // chance of an idle cycle on either side
	localparam int STALL_CYCLES  = 400;  // long receiver hold-off
	// three scans in flight (two queued, one in the back end)
	localparam int SETTLE_CYCLES = 160;
	localparam int MAX_REPORTS   = 10;

	// one key event as the block emits it
	typedef struct packed {
		logic [1:0] row;
		logic [4:0] key;
		logic       press;
		logic [1:0] mod;
		logic       last;
	} key_event_t;

	// ------------------------------------------------------------------
	// Clock, reset and DUT ports; every input starts at a known value
	// ------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	// [3:0] first set rows 0..3, [7:4] second set rows 0..3
	logic [7:0][15:0]     scan_bus  = '0;

	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           row_index;
	logic [4:0]           key_index;
	logic                 is_press;
	logic [1:0]           modifier;
	logic                 last_event;

	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEVEL_W-1:0]   cfg_data  = '0;

	always #1 clk = ~clk;

	resistor_ladder_key_scanner_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.first_sample_a  (scan_bus[0]),
		.first_sample_b  (scan_bus[1]),
		.first_sample_c  (scan_bus[2]),
		.first_sample_d  (scan_bus[3]),
		.second_sample_a (scan_bus[4]),
		.second_sample_b (scan_bus[5]),
		.second_sample_c (scan_bus[6]),
		.second_sample_d (scan_bus[7]),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.row_index       (row_index),
		.key_index       (key_index),
		.is_press        (is_press),
		.modifier        (modifier),
		.last_event      (last_event),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// ------------------------------------------------------------------
	// Shadow state of the scanner: per-row scales and last accepted levels
	// ------------------------------------------------------------------
	logic [4:0]       row_scale  [ROWS];
	logic [4:0]       held_level [ROWS];

	logic [7:0][15:0] scan_fifo [$];       // scans waiting for the driver
	key_event_t       pending_events [$];  // events predicted, not yet seen

	logic             scan_taken    = 1'b0;  // input transaction at last rising edge
	int               src_idle_pct  = IDLE_PCT;
	int               sink_idle_pct = IDLE_PCT;
	int               stall_req     = 0;     // bumped by the sequence to request a hold-off
	int               stall_ack     = 0;
	int               stall_left    = 0;
	int               fail_count    = 0;

	// levels the stimulus generator last aimed for; lets rows repeat
	logic [3:0][4:0]  gen_level = '1;

	// Quantize one set of four samples: negatives clamp to zero, each row is
	// round-half-up of sample * scale / set maximum, and a level equal to the
	// row's scale reads as no key. An all-zero set reads no key on every row.
	function automatic logic [3:0][4:0] ladder_levels(input logic [3:0][15:0] set);
		int unsigned     amp [ROWS];
		int unsigned     peak;
		int unsigned     q;
		logic [3:0][4:0] lv;
		peak = 0;
		for (int i = 0; i < ROWS; i++) begin
			amp[i] = set[i][15] ? 0 : 32'(set[i]);
			if (amp[i] > peak)
				peak = amp[i];
		end
		for (int i = 0; i < ROWS; i++) begin
			if (peak == 0) begin
				lv[i] = rlks_pkg::NO_KEY;
			end else begin
				q = (2 * amp[i] * 32'(row_scale[i]) + peak) / (2 * peak);
				lv[i] = (q == 32'(row_scale[i])) ? rlks_pkg::NO_KEY : q[4:0];
			end
		end
		return lv;
	endfunction

	// Turn one accepted scan into the key events it should cause.
	function automatic void predict_key_events(input logic [7:0][15:0] scan);
		logic [3:0][4:0] lv_a;
		logic [3:0][4:0] lv_b;
		logic [1:0]      mod;
		key_event_t      batch [8];
		int              n;
		lv_a = ladder_levels(scan[3:0]);
		lv_b = ladder_levels(scan[7:4]);
		// the two sets disagree: scan is dropped, stored levels stay
		if (lv_a != lv_b)
			return;
		if (lv_a[1] == 5'd0)
			mod = rlks_pkg::MOD_EXTRA;
		else if (lv_a[1] == 5'd1)
			mod = rlks_pkg::MOD_SHIFT;
		else
			mod = rlks_pkg::MOD_NONE;
		n = 0;
		for (int i = 0; i < ROWS; i++) begin
			if (lv_a[i] != held_level[i]) begin
				// release of the old key comes ahead of the press of the new one
				if (held_level[i] != rlks_pkg::NO_KEY) begin
					batch[n] = '{row: i[1:0], key: held_level[i], press: 1'b0,
						mod: mod, last: 1'b0};
					n++;
				end
				if (lv_a[i] != rlks_pkg::NO_KEY) begin
					batch[n] = '{row: i[1:0], key: lv_a[i], press: 1'b1,
						mod: mod, last: 1'b0};
					n++;
				end
				held_level[i] = lv_a[i];
			end
		end
		if (n > 0)
			batch[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			pending_events.push_back(batch[k]);
	endfunction

	// ------------------------------------------------------------------
	// Rising edge: check output transactions, mirror config writes and
	// predict from input transactions
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		key_event_t got;
		key_event_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{row: row_index, key: key_index, press: is_press,
					mod: modifier, last: last_event};
				if (pending_events.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("[%0t] unexpected event: row=%0d key=%0d press=%0b mod=%0d last=%0b",
							$realtime, got.row, got.key, got.press, got.mod, got.last);
				end else begin
					want = pending_events.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"[%0t] event mismatch: expected row=%0d key=%0d press=%0b",
								" mod=%0d last=%0b, got row=%0d key=%0d press=%0b mod=%0d last=%0b"},
								$realtime, want.row, want.key, want.press, want.mod, want.last,
								got.row, got.key, got.press, got.mod, got.last);
					end
				end
			end
			if (cfg_we && cfg_index < ROWS)
				row_scale[cfg_index[1:0]] = cfg_data;
			if (in_valid && in_ready)
				predict_key_events(scan_bus);
			scan_taken <= in_valid && in_ready;
		end
	end

	// ------------------------------------------------------------------
	// Driver: presents the next scan at the falling edge once the slot is
	// free, with random gaps between transactions
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!in_valid || scan_taken)) begin
			if (scan_fifo.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				scan_bus <= scan_fifo.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random back-pressure, plus a long hold-off on request that
	// lets the block fill up and drop in_ready
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_req != stall_ack) begin
			stall_ack  = stall_req;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic set_scales(input logic [4:0] s0, input logic [4:0] s1,
		input logic [4:0] s2, input logic [4:0] s3);
		cfg_write(REG_SCALE_ROW_ZERO,  s0);
		cfg_write(REG_SCALE_ROW_ONE,   s1);
		cfg_write(REG_SCALE_ROW_TWO,   s2);
		cfg_write(REG_SCALE_ROW_THREE, s3);
	endtask

	// Everything sent, every event back, then the tail for scans that
	// produce nothing but may still sit in the block.
	task automatic wait_drained();
		while (scan_fifo.size() != 0 || in_valid || pending_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Build a set that quantizes to the wanted levels under the current
	// scales. Row mrow carries the set maximum and so always reads no key.
	function automatic logic [3:0][15:0] build_set(input logic [3:0][4:0] lv,
		input int mrow, input int unsigned peak);
		logic [3:0][15:0] set;
		int unsigned      sc;
		int unsigned      lvl;
		for (int i = 0; i < ROWS; i++) begin
			sc = 32'(row_scale[i]);
			if (i == mrow) begin
				set[i] = 16'(peak);
			end else if (sc == 0) begin
				set[i] = 16'($urandom_range(peak));
			end else begin
				lvl = (32'(lv[i]) > sc) ? sc : 32'(lv[i]);
				set[i] = 16'((lvl * peak + sc / 2) / sc);
			end
		end
		return set;
	endfunction

	task automatic push_levels(input logic [3:0][4:0] lv, input int mrow, input int unsigned peak);
		logic [3:0][15:0] set;
		set = build_set(lv, mrow, peak);
		scan_fifo.push_back({set, set});
	endtask

	// Consistent scan with random levels; rows often keep their last level so
	// the unchanged, release-only and release-then-press paths all get hit.
	task automatic push_wellformed();
		logic [3:0][4:0]  lv;
		logic [3:0][15:0] a;
		logic [3:0][15:0] b;
		int               mrow;
		int unsigned      peak;
		mrow = $urandom_range(ROWS - 1);
		peak = ($urandom_range(9) == 0) ? 32767 : $urandom_range(32767, 64);
		for (int i = 0; i < ROWS; i++)
			lv[i] = ($urandom_range(99) < 40) ? gen_level[i] :
				5'($urandom_range(32'(row_scale[i])));
		a = build_set(lv, mrow, peak);
		b = a;
		for (int i = 0; i < ROWS; i++) begin
			// a zero sample may just as well be negative, differently per set
			if (i != mrow && a[i] == 0 && $urandom_range(3) == 0) begin
				a[i] = 16'h8000 | 16'($urandom_range(16'h7fff));
				b[i] = 16'h8000 | 16'($urandom_range(16'h7fff));
			end else if (i != mrow && $urandom_range(4) == 0) begin
				b[i] = a[i] + 16'($urandom_range(1));  // ADC noise, may flip a rounding
			end
		end
		gen_level = lv;
		scan_fifo.push_back({b, a});
	endtask

	task automatic push_random(input int count);
		int               pick;
		logic [3:0][15:0] a;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				push_wellformed();
			end else if (pick < 88) begin
				a = {$urandom, $urandom};  // raw samples, both sets agree
				scan_fifo.push_back({a, a});
			end else begin
				scan_fifo.push_back({$urandom, $urandom, $urandom, $urandom});
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [3:0][15:0] a;
		logic [3:0][15:0] b;
		for (int i = 0; i < ROWS; i++) begin
			row_scale[i]  = rlks_pkg::SCALE_RESET[i];
			held_level[i] = rlks_pkg::NO_KEY;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed, reset scales 16 / 2 / 15 / 16 ---
		scan_fifo.push_back('0);                  // set maximum zero
		scan_fifo.push_back({8{16'h8000}});       // all most negative, clamps to zero
		// presses, extra modifier
		push_levels({5'd9, 5'd5, 5'd0, rlks_pkg::NO_KEY}, 0, 32767);
		// nothing changed
		push_levels({5'd9, 5'd5, 5'd0, rlks_pkg::NO_KEY}, 0, 32767);
		// row 0 press, row 1 key to other key with shift, row 2 key to no key
		push_levels({5'd9, rlks_pkg::NO_KEY, 5'd1, 5'd3}, 2, 32767);
		// two sets that disagree: dropped, state kept
		a = build_set({5'd2, 5'd4, rlks_pkg::NO_KEY, 5'd7}, 1, 30000);
		b = build_set({5'd2, 5'd4, rlks_pkg::NO_KEY, 5'd8}, 1, 30000);
		scan_fifo.push_back({b, a});
		// negative samples on rows 0 and 3 read as level 0
		a = build_set({5'd0, 5'd7, rlks_pkg::NO_KEY, 5'd0}, 1, 20000);
		a[3] = 16'hffff;
		b = a;
		a[0] = 16'h8001;
		b[0] = 16'h8000;
		scan_fifo.push_back({b, a});
		// maximum of one
		a = {16'h0000, 16'h0000, 16'h0000, 16'h0001};
		b = {16'hfffb, 16'h0000, 16'h0000, 16'h0001};
		scan_fifo.push_back({b, a});
		// exact halves round up: row 0 1*16/32, row 3 3*16/32
		a = {16'd3, 16'd20, 16'd32, 16'd1};
		scan_fifo.push_back({a, a});
		scan_fifo.push_back({8{16'h7fff}});       // every row at the maximum: all released
		scan_fifo.push_back({{4{16'h2aaa}}, {4{16'h5555}}});
		push_levels({5'd15, 5'd14, 5'd1, 5'd16}, 0, 32767);
		push_levels({rlks_pkg::NO_KEY, rlks_pkg::NO_KEY, rlks_pkg::NO_KEY, 5'd0}, 3, 1000);
		push_random(30);
		wait_drained();

		// --- scale extremes, including 0 and 31; spare indexes ignored ---
		set_scales(5'd1, 5'd30, 5'd31, 5'd0);
		for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
			cfg_write(CFG_IDX_W'(r), LEVEL_W'($urandom));
		push_levels({5'd0, 5'd30, 5'd29, 5'd0}, 3, 32767);
		push_levels({5'd0, 5'd0, 5'd15, 5'd1}, 2, 32767);
		push_random(30);
		wait_drained();

		// --- long receiver hold-off while the sender keeps offering ---
		set_scales(5'd30, 5'd1, 5'd0, 5'd31);
		src_idle_pct = 0;
		stall_req++;
		push_random(30);
		wait_drained();
		src_idle_pct = IDLE_PCT;

		// --- reset scales again, no idling on either side ---
		set_scales(rlks_pkg::SCALE_RESET[0], rlks_pkg::SCALE_RESET[1],
			rlks_pkg::SCALE_RESET[2], rlks_pkg::SCALE_RESET[3]);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		push_random(30);
		wait_drained();
		src_idle_pct  = IDLE_PCT;
		sink_idle_pct = IDLE_PCT;

		// --- random scales ---
		set_scales(5'($urandom_range(31)), 5'($urandom_range(31)),
			5'($urandom_range(31)), 5'($urandom_range(31)));
		push_random(30);
		wait_drained();

		if (fail_count == 0)
			$display("** resistor_ladder_key_scanner_core: PASSED **");
		else
			$display("** resistor_ladder_key_scanner_core: FAILED **");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#400000;
		$display("** resistor_ladder_key_scanner_core: FAILED **");
		$finish;
	end

endmodule
